FILE: hw/rtl/gmdfs_pkg.sv
package gmdfs_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 32;
    localparam int STACK_DEPTH = 128;

    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int POS_W      = ROW_W + COL_W;
    localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;
    localparam int STK_AW     = $clog2(STACK_DEPTH);
    localparam int CNT_W      = STK_AW + 1;

    localparam int ROWS_CFG_W = 5;
    localparam int COLS_CFG_W = 6;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int KIND_W     = 2;
    localparam int CELL_W     = 2;
    localparam int STATUS_W   = 2;

    // neighbor arithmetic width: holds a coordinate up to 64 plus a wrapped -1
    localparam int NB_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 5'd13;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 6'd17;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

    localparam logic [CELL_W-1:0] CELL_OPEN  = 2'd0;
    localparam logic [CELL_W-1:0] CELL_WALL  = 2'd1;
    localparam logic [CELL_W-1:0] CELL_START = 2'd2;
    localparam logic [CELL_W-1:0] CELL_END   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_MOVED   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ARRIVED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FAILED  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IDLE    = 2'd3;

    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_SEARCH  = 2'd1;
    localparam logic [1:0] PHASE_ARRIVED = 2'd2;
    localparam logic [1:0] PHASE_FAILED  = 2'd3;

    typedef struct packed {
        logic              visited;
        logic [CELL_W-1:0] cell_type;
    } grid_entry_t;

    typedef struct packed {
        logic signed [1:0] dr;
        logic signed [1:0] dc;
    } nbr_step_t;

    // scan order: E, SE, S, SW, W, NW, N, NE
    function automatic nbr_step_t nbr_step(input logic [2:0] k);
        nbr_step_t s;
        unique case (k)
            3'd0: s = '{dr:  2'sd0, dc:  2'sd1};
            3'd1: s = '{dr:  2'sd1, dc:  2'sd1};
            3'd2: s = '{dr:  2'sd1, dc:  2'sd0};
            3'd3: s = '{dr:  2'sd1, dc: -2'sd1};
            3'd4: s = '{dr:  2'sd0, dc: -2'sd1};
            3'd5: s = '{dr: -2'sd1, dc: -2'sd1};
            3'd6: s = '{dr: -2'sd1, dc:  2'sd0};
            3'd7: s = '{dr: -2'sd1, dc:  2'sd1};
            default: s = '{dr: 2'sd0, dc: 2'sd0};
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/grid_maze_depth_first_search.sv
// Depth-first maze walker over a 16 x 32 grid with eight-way moves. Every input
// transaction returns exactly one result transaction. A load replaces the cell type
// and returns its result; a step reads the current cell and, unless it is the end
// cell, scans the neighbors through the single read port of the grid memory and,
// unless the stack is empty, does one stack read for the pop; a step outside an
// active search returns its result directly. A start clears the visited marks held
// next to the cell types in the grid memory one entry per cycle; the same pass runs
// after reset, during which no input transaction is taken. Configuration writes are
// taken in any cycle.
module grid_maze_depth_first_search (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gmdfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gmdfs_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [gmdfs_pkg::KIND_W-1:0]       s_kind,
    input  logic [gmdfs_pkg::ROW_W-1:0]        s_row,
    input  logic [gmdfs_pkg::COL_W-1:0]        s_col,
    input  logic [gmdfs_pkg::CELL_W-1:0]       s_cell_req,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [gmdfs_pkg::ROW_W-1:0]        m_cur_row,
    output logic [gmdfs_pkg::COL_W-1:0]        m_cur_col,
    output logic [gmdfs_pkg::STATUS_W-1:0]     m_status,
    output logic                               m_overflow
);
    import gmdfs_pkg::*;

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_LOAD_WR  = 4'd2;
    localparam logic [3:0] ST_CUR_CHK  = 4'd3;
    localparam logic [3:0] ST_SCAN     = 4'd4;
    localparam logic [3:0] ST_POP      = 4'd5;
    localparam logic [3:0] ST_POP_WAIT = 4'd6;
    localparam logic [3:0] ST_DONE     = 4'd7;

    localparam logic [POS_W:0] CLR_END   = (POS_W + 1)'(GRID_CELLS);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    logic [3:0]              state_reg, state_next;
    logic [POS_W:0]          clr_ctr_reg, clr_ctr_next;
    logic                    clr_start_reg, clr_start_next;
    logic [ROWS_CFG_W-1:0]   rows_cfg_reg, rows_cfg_next;
    logic [COLS_CFG_W-1:0]   cols_cfg_reg, cols_cfg_next;
    logic [POS_W-1:0]        item_pos_reg, item_pos_next;
    logic [CELL_W-1:0]       item_req_reg, item_req_next;
    logic [POS_W-1:0]        start_pos_reg, start_pos_next;
    logic [POS_W-1:0]        cur_pos_reg, cur_pos_next;
    logic [1:0]              phase_reg, phase_next;
    logic                    ovf_reg, ovf_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [3:0]              k_reg, k_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]        pend_pos_reg, pend_pos_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;

    logic                    m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]        m_cur_row_reg, m_cur_row_next;
    logic [COL_W-1:0]        m_cur_col_reg, m_cur_col_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic                    m_overflow_reg, m_overflow_next;

    grid_entry_t             grid_mem [GRID_CELLS];
    grid_entry_t             grid_rdata_reg;
    logic [POS_W-1:0]        grid_raddr;
    logic                    grid_we;
    logic [POS_W-1:0]        grid_waddr;
    grid_entry_t             grid_wdata;

    logic [POS_W-1:0]        stk_mem [STACK_DEPTH];
    logic [POS_W-1:0]        stk_rdata_reg;
    logic [STK_AW-1:0]       stk_raddr;
    logic                    stk_we;
    logic [CNT_W-1:0]        count_dec;
    logic [POS_W:0]          clr_prev;

    nbr_step_t               nstep;
    logic [NB_W-1:0]         nb_row, nb_col, lim_row, lim_col;
    logic                    nb_inb;
    logic [POS_W-1:0]        nb_pos;

    logic                    s_acc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;

    assign m_valid    = m_valid_reg;
    assign m_cur_row  = m_cur_row_reg;
    assign m_cur_col  = m_cur_col_reg;
    assign m_status   = m_status_reg;
    assign m_overflow = m_overflow_reg;

    // neighbor k of the current cell; a negative coordinate wraps high and fails the bound
    always_comb begin
        nstep   = nbr_step(k_reg[2:0]);
        nb_row  = NB_W'(cur_pos_reg[POS_W-1:COL_W]) + {{(NB_W-2){nstep.dr[1]}}, nstep.dr};
        nb_col  = NB_W'(cur_pos_reg[COL_W-1:0]) + {{(NB_W-2){nstep.dc[1]}}, nstep.dc};
        lim_row = (NB_W'(rows_cfg_reg) > NB_W'(MAX_ROWS)) ? NB_W'(MAX_ROWS)
                                                          : NB_W'(rows_cfg_reg);
        lim_col = (NB_W'(cols_cfg_reg) > NB_W'(MAX_COLS)) ? NB_W'(MAX_COLS)
                                                          : NB_W'(cols_cfg_reg);
        nb_inb  = (nb_row < lim_row) && (nb_col < lim_col);
        nb_pos  = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};
    end

    assign count_dec = count_reg - 1'b1;
    assign stk_raddr = count_dec[STK_AW-1:0];
    assign clr_prev  = clr_ctr_reg - 1'b1;

    always_comb begin
        state_next      = state_reg;
        clr_ctr_next    = clr_ctr_reg;
        clr_start_next  = clr_start_reg;
        rows_cfg_next   = rows_cfg_reg;
        cols_cfg_next   = cols_cfg_reg;
        item_pos_next   = item_pos_reg;
        item_req_next   = item_req_reg;
        start_pos_next  = start_pos_reg;
        cur_pos_next    = cur_pos_reg;
        phase_next      = phase_reg;
        ovf_next        = ovf_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_cur_row_next  = m_cur_row_reg;
        m_cur_col_next  = m_cur_col_reg;
        m_status_next   = m_status_reg;
        m_overflow_next = m_overflow_reg;
        grid_raddr      = cur_pos_reg;
        grid_we         = 1'b0;
        grid_waddr      = cur_pos_reg;
        grid_wdata      = grid_rdata_reg;
        stk_we          = 1'b0;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ROWS: rows_cfg_next = cfg_data[ROWS_CFG_W-1:0];
                REG_COLS: cols_cfg_next = cfg_data[COLS_CFG_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                // read entry n while writing back entry n-1 with its mark dropped
                if (clr_ctr_reg != CLR_END) begin
                    grid_raddr = clr_ctr_reg[POS_W-1:0];
                end
                if (clr_ctr_reg != '0) begin
                    grid_we    = 1'b1;
                    grid_waddr = clr_prev[POS_W-1:0];
                    grid_wdata = '{visited: 1'b0, cell_type: grid_rdata_reg.cell_type};
                end
                if (clr_ctr_reg == CLR_END) begin
                    if (clr_start_reg) begin
                        res_status_next = STATUS_IDLE;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    clr_ctr_next = clr_ctr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                grid_raddr = (s_kind == KIND_STEP) ? cur_pos_reg : {s_row, s_col};
                if (s_acc) begin
                    item_pos_next = {s_row, s_col};
                    item_req_next = s_cell_req;
                    unique case (s_kind)
                        KIND_LOAD: state_next = ST_LOAD_WR;
                        KIND_START: begin
                            count_next     = '0;
                            ovf_next       = 1'b0;
                            cur_pos_next   = start_pos_reg;
                            phase_next     = PHASE_SEARCH;
                            clr_ctr_next   = '0;
                            clr_start_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        KIND_STEP: begin
                            unique case (phase_reg)
                                PHASE_SEARCH:  state_next = ST_CUR_CHK;
                                PHASE_ARRIVED: begin
                                    res_status_next = STATUS_ARRIVED;
                                    state_next      = ST_DONE;
                                end
                                PHASE_FAILED: begin
                                    res_status_next = STATUS_FAILED;
                                    state_next      = ST_DONE;
                                end
                                default: begin
                                    res_status_next = STATUS_IDLE;
                                    state_next      = ST_DONE;
                                end
                            endcase
                        end
                        default: begin
                            res_status_next = STATUS_IDLE;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_LOAD_WR: begin
                // keep the visited mark, replace the cell type
                grid_we    = 1'b1;
                grid_waddr = item_pos_reg;
                grid_wdata = '{visited: grid_rdata_reg.visited, cell_type: item_req_reg};
                if (item_req_reg == CELL_START) begin
                    start_pos_next = item_pos_reg;
                end
                res_status_next = STATUS_IDLE;
                state_next      = ST_DONE;
            end
            ST_CUR_CHK: begin
                if (grid_rdata_reg.cell_type == CELL_END) begin
                    phase_next      = PHASE_ARRIVED;
                    res_status_next = STATUS_ARRIVED;
                    state_next      = ST_DONE;
                end else begin
                    grid_we         = 1'b1;
                    grid_waddr      = cur_pos_reg;
                    grid_wdata      = '{visited: 1'b1, cell_type: grid_rdata_reg.cell_type};
                    k_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // check the neighbor read last cycle, issue the read of the next one
                if (pend_valid_reg && grid_rdata_reg.cell_type != CELL_WALL
                        && !grid_rdata_reg.visited) begin
                    if (count_reg < CNT_FULL) begin
                        stk_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                if (!k_reg[3]) begin
                    grid_raddr      = nb_pos;
                    pend_valid_next = nb_inb;
                    pend_pos_next   = nb_pos;
                    k_next          = k_reg + 1'b1;
                end else begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_POP;
                end
            end
            ST_POP: begin
                if (count_reg == '0) begin
                    phase_next      = PHASE_FAILED;
                    res_status_next = STATUS_FAILED;
                    state_next      = ST_DONE;
                end else begin
                    count_next = count_dec;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: begin
                cur_pos_next    = stk_rdata_reg;
                res_status_next = STATUS_MOVED;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_cur_row_next  = cur_pos_reg[POS_W-1:COL_W];
                    m_cur_col_next  = cur_pos_reg[COL_W-1:0];
                    m_status_next   = res_status_reg;
                    m_overflow_next = ovf_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_ctr_reg    <= '0;
            clr_start_reg  <= 1'b0;
            rows_cfg_reg   <= ROWS_RESET;
            cols_cfg_reg   <= COLS_RESET;
            start_pos_reg  <= '0;
            cur_pos_reg    <= '0;
            phase_reg      <= PHASE_IDLE;
            ovf_reg        <= 1'b0;
            count_reg      <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_ctr_reg    <= clr_ctr_next;
            clr_start_reg  <= clr_start_next;
            rows_cfg_reg   <= rows_cfg_next;
            cols_cfg_reg   <= cols_cfg_next;
            start_pos_reg  <= start_pos_next;
            cur_pos_reg    <= cur_pos_next;
            phase_reg      <= phase_next;
            ovf_reg        <= ovf_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_pos_reg   <= item_pos_next;
        item_req_reg   <= item_req_next;
        pend_pos_reg   <= pend_pos_next;
        res_status_reg <= res_status_next;
        m_cur_row_reg  <= m_cur_row_next;
        m_cur_col_reg  <= m_cur_col_next;
        m_status_reg   <= m_status_next;
        m_overflow_reg <= m_overflow_next;
    end

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        grid_rdata_reg <= grid_mem[grid_raddr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[count_reg[STK_AW-1:0]] <= pend_pos_reg;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("stack count above depth");

    a_push_below_full: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_we |-> (count_reg < CNT_FULL) && (state_reg == ST_SCAN))
        else $error("stack write with full stack or outside scan");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (state_reg != ST_IDLE))
        else $error("accepted transaction produced no work");

    a_scan_no_grid_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !grid_we)
        else $error("grid write during neighbor scan");

    a_done_needs_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP_WAIT) |-> (phase_reg == PHASE_SEARCH) && $past(count_reg != '0))
        else $error("pop without an active search or stack entry");

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import gmdfs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
    localparam int ITEM_TARGET = 1500;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [STATUS_W-1:0] status;
        logic                ovf;
    } walk_result_t;

    // Tracks the maze walker and holds the results it still owes, oldest first.
    class maze_scoreboard;
        logic [CELL_W-1:0] cells [GRID_CELLS];
        bit                visited [GRID_CELLS];
        logic [POS_W-1:0]  pos_stack [STACK_DEPTH];
        int                depth_used;
        logic [POS_W-1:0]  here;
        logic [POS_W-1:0]  start_pos;
        logic [1:0]        phase;
        bit                ovf;
        int                row_lim;
        int                col_lim;
        walk_result_t      owed_results [$];
        int                mismatches;
        int                results_seen;
        int                status_seen [4];
        int                ovf_seen;

        function new();
            depth_used = 0;
            here       = '0;
            start_pos  = '0;
            phase      = PHASE_IDLE;
            ovf        = 1'b0;
            row_lim    = int'(ROWS_RESET);
            col_lim    = int'(COLS_RESET);
            foreach (visited[i]) visited[i] = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ROWS)
                row_lim = int'(data[ROWS_CFG_W-1:0]);
            else
                col_lim = int'(data[COLS_CFG_W-1:0]);
        endfunction

        // One search step: arrive, or mark, push free neighbors and pop, or fail on an empty stack.
        function logic [STATUS_W-1:0] walk_step();
            int drow [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
            int dcol [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
            int r, c, nr, nc, lr, lc, p;
            if (phase == PHASE_IDLE)
                return STATUS_IDLE;
            if (phase == PHASE_ARRIVED)
                return STATUS_ARRIVED;
            if (phase == PHASE_FAILED)
                return STATUS_FAILED;
            if (cells[here] == CELL_END) begin
                phase = PHASE_ARRIVED;
                return STATUS_ARRIVED;
            end
            visited[here] = 1'b1;
            r  = int'(here) / MAX_COLS;
            c  = int'(here) % MAX_COLS;
            lr = row_lim > MAX_ROWS ? MAX_ROWS : row_lim;
            lc = col_lim > MAX_COLS ? MAX_COLS : col_lim;
            for (int k = 0; k < 8; k++) begin
                nr = r + drow[k];
                nc = c + dcol[k];
                if (nr >= 0 && nc >= 0 && nr < lr && nc < lc) begin
                    p = nr * MAX_COLS + nc;
                    if (cells[p] != CELL_WALL && !visited[p]) begin
                        if (depth_used >= STACK_DEPTH) begin
                            ovf = 1'b1;   // drop the push
                        end else begin
                            pos_stack[depth_used] = POS_W'(p);
                            depth_used++;
                        end
                    end
                end
            end
            if (depth_used == 0) begin
                phase = PHASE_FAILED;
                return STATUS_FAILED;
            end
            depth_used--;
            here = pos_stack[depth_used];
            return STATUS_MOVED;
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] row,
                                logic [COL_W-1:0] col, logic [CELL_W-1:0] req);
            walk_result_t want;
            logic [POS_W-1:0] pos;
            want.status = STATUS_IDLE;
            pos = POS_W'(int'(row) * MAX_COLS + int'(col));
            case (kind)
                KIND_LOAD: begin
                    cells[pos] = req;
                    if (req == CELL_START)
                        start_pos = pos;
                end
                KIND_START: begin
                    foreach (visited[i]) visited[i] = 1'b0;
                    depth_used = 0;
                    ovf        = 1'b0;
                    here       = start_pos;
                    phase      = PHASE_SEARCH;
                end
                KIND_STEP: want.status = walk_step();
                default: ;
            endcase
            want.row = ROW_W'(int'(here) / MAX_COLS);
            want.col = COL_W'(int'(here) % MAX_COLS);
            want.ovf = ovf;
            owed_results.push_back(want);
        endfunction

        function void check_result(walk_result_t got);
            walk_result_t want;
            results_seen++;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected result: row %0d col %0d status %0d overflow %0d",
                             got.row, got.col, got.status, got.ovf);
                return;
            end
            want = owed_results.pop_front();
            status_seen[want.status]++;
            if (want.ovf)
                ovf_seen++;
            if (got.row !== want.row || got.col !== want.col ||
                got.status !== want.status || got.ovf !== want.ovf) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display({"result %0d mismatch: expected row %0d col %0d status %0d ",
                              "overflow %0d, got row %0d col %0d status %0d overflow %0d"},
                             results_seen, want.row, want.col, want.status, want.ovf,
                             got.row, got.col, got.status, got.ovf);
            end
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic              s_valid    = 1'b0;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind     = '0;
    logic [ROW_W-1:0]  s_row      = '0;
    logic [COL_W-1:0]  s_col      = '0;
    logic [CELL_W-1:0] s_cell_req = '0;

    logic                m_valid;
    logic                m_ready = 1'b1;
    logic [ROW_W-1:0]    m_cur_row;
    logic [COL_W-1:0]    m_cur_col;
    logic [STATUS_W-1:0] m_status;
    logic                m_overflow;

    maze_scoreboard sb = new();

    bit tx_quiet   = 1'b0;
    bit rx_quiet   = 1'b0;
    int ready_hold = 0;
    int items_sent = 0;
    int searches   = 0;
    int settings   = 0;

    grid_maze_depth_first_search u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_row      (s_row),
        .s_col      (s_col),
        .s_cell_req (s_cell_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cur_row  (m_cur_row),
        .m_cur_col  (m_cur_col),
        .m_status   (m_status),
        .m_overflow (m_overflow)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_cur_row, m_cur_col, m_status, m_overflow});
    end

    // Randomly hold off the result channel after a result is taken, unless rx_quiet is set.
    always @(posedge aclk) begin
        int hold;
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            if (ready_hold == 1)
                m_ready <= 1'b1;
        end else if (aresetn && m_valid && m_ready) begin
            hold = rx_quiet ? 0 : $urandom_range(0, 6);
            if (hold != 0) begin
                m_ready    <= 1'b0;
                ready_hold <= hold;
            end
        end
    end

    task automatic send_item(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] row,
                             logic [COL_W-1:0] col, logic [CELL_W-1:0] req);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_row      <= row;
        s_col      <= col;
        s_cell_req <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(kind, row, col, req);
        if (kind != KIND_NOP)
            items_sent++;
    endtask

    task automatic send_load(int row, int col, logic [CELL_W-1:0] req);
        send_item(KIND_LOAD, ROW_W'(row), COL_W'(col), req);
    endtask

    // Non-load items carry random payload so every input bit toggles.
    task automatic send_cmd(logic [KIND_W-1:0] kind);
        send_item(kind, ROW_W'($urandom), COL_W'($urandom), CELL_W'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.owed_results.size() != 0);
    endtask

    // Write both bound registers back to back; call only with the block idle.
    task automatic set_bounds(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols);
        cfg_valid <= 1'b1;
        cfg_index <= REG_ROWS;
        cfg_data  <= rows;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(REG_ROWS, rows);
        cfg_index <= REG_COLS;
        cfg_data  <= cols;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(REG_COLS, cols);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [CELL_W-1:0] pick_cell();
        int x;
        x = $urandom_range(0, 99);
        if (x < 15)
            return CELL_WALL;
        if (x < 16)
            return CELL_END;
        if (x < 17)
            return CELL_START;
        return CELL_OPEN;
    endfunction

    task automatic run_search();
        int style, rows, cols, er, ec, cap, n, pick;
        style = (searches == 0) ? 0 : $urandom_range(0, 9);
        drain();
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        if (searches == 0) begin
            rows = 31;
            cols = 63;
        end else if (style == 0) begin
            rows = $urandom_range(16, 31);
            cols = $urandom_range(32, 63);
        end else if (style == 1) begin
            rows = $urandom_range(0, 1) ? 0 : $urandom_range(0, 31);
            cols = (rows == 0) ? $urandom_range(0, 63) : 0;
        end else if (style < 5) begin
            rows = $urandom_range(4, 16);
            cols = $urandom_range(4, 32);
        end else begin
            rows = $urandom_range(1, 6);
            cols = $urandom_range(1, 8);
        end
        cap = (style == 0) ? 200 : (style == 1) ? 4 : (style < 5) ? 120 : 50;
        // Bit 5 of the row register data is unused by the block.
        set_bounds(CFG_DATA_W'(rows) | (CFG_DATA_W'($urandom_range(0, 1)) << 5),
                   CFG_DATA_W'(cols));
        er = rows > MAX_ROWS ? MAX_ROWS : rows;
        ec = cols > MAX_COLS ? MAX_COLS : cols;
        if (er != 0 && ec != 0) begin
            send_load($urandom_range(0, er - 1), $urandom_range(0, ec - 1), CELL_START);
            if (style != 0 && $urandom_range(0, 1))
                send_load($urandom_range(0, er - 1), $urandom_range(0, ec - 1), CELL_END);
        end
        repeat ($urandom_range(0, 4))
            send_load($urandom_range(0, 15), $urandom_range(0, 31), pick_cell());
        send_cmd(KIND_START);
        n = 0;
        while (n < cap && sb.phase == PHASE_SEARCH) begin
            pick = $urandom_range(0, 23);
            if (pick == 0)
                send_cmd(KIND_NOP);
            else if (pick == 1)
                send_load($urandom_range(0, 15), $urandom_range(0, 31), CELL_W'($urandom));
            else if (pick == 2 && $urandom_range(0, 3) == 0)
                send_cmd(KIND_START);
            else
                send_cmd(KIND_STEP);
            n++;
        end
        repeat ($urandom_range(0, 2))
            send_cmd(KIND_STEP);
        searches++;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: searches with 1 x 1 and 0 x 0 bounds before the full grid load.
        send_cmd(KIND_STEP);
        send_cmd(KIND_NOP);
        send_load(15, 31, CELL_END);
        send_load(15, 0, CELL_WALL);
        send_load(0, 31, CELL_OPEN);
        send_load(7, 9, CELL_START);
        send_load(0, 0, CELL_START);
        drain();
        set_bounds(CFG_DATA_W'(1), CFG_DATA_W'(1));
        send_cmd(KIND_START);
        send_cmd(KIND_STEP);
        send_cmd(KIND_STEP);
        send_cmd(KIND_START);
        send_load(0, 0, CELL_END);
        send_cmd(KIND_STEP);
        send_cmd(KIND_STEP);
        drain();
        set_bounds('0, '0);
        send_load(0, 0, CELL_OPEN);
        send_cmd(KIND_START);
        send_cmd(KIND_STEP);
        send_cmd(KIND_NOP);

        for (int r = 0; r < MAX_ROWS; r++)
            for (int c = 0; c < MAX_COLS; c++)
                send_load(r, c, pick_cell());

        while (items_sent < ITEM_TARGET)
            run_search();

        drain();
        repeat (20) @(posedge aclk);

        $display("%0d items, %0d searches over %0d bound settings, %0d results checked",
                 items_sent, searches, settings, sb.results_seen);
        $display("moves %0d, arrivals %0d, failures %0d, idle/load %0d, overflow set on %0d",
                 sb.status_seen[STATUS_MOVED], sb.status_seen[STATUS_ARRIVED],
                 sb.status_seen[STATUS_FAILED], sb.status_seen[STATUS_IDLE], sb.ovf_seen);
        if (sb.owed_results.size() != 0)
            $display("%0d expected results never arrived", sb.owed_results.size());
        if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", sb.owed_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: grid_maze_depth_first_search.f
hw/rtl/gmdfs_pkg.sv
hw/rtl/grid_maze_depth_first_search.sv
dv/tb_top.sv
